// ===== design/tdwa_pkg.sv =====
// Shared types, constants and weight tables for the touch de-jitter filter.
package tdwa_pkg;

  localparam int COORD_BITS  = 12;
  localparam int HIST_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(HIST_DEPTH);
  localparam int CNT_BITS    = PTR_BITS + 1;
  localparam int THRESH_BITS = COORD_BITS + 1;
  localparam int WEIGHT_BITS = 4;
  localparam int ACC_BITS    = COORD_BITS + WEIGHT_BITS;
  localparam int SHIFT_BITS  = 3;

  localparam logic [THRESH_BITS-1:0] JUMP_RESET = THRESH_BITS'(100);

  // One input item: a coordinate pair or a pen-up marker.
  typedef struct packed {
    logic                  pen_up;
    logic [COORD_BITS-1:0] sample_x;
    logic [COORD_BITS-1:0] sample_y;
  } in_t;

  // One result item: a filtered coordinate pair.
  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
  } out_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic                   clr;
    logic                   en;
    logic [WEIGHT_BITS-1:0] weight;
  } mac_ctl_t;

  // Weight of the history entry idx (0 is newest) for a given fill count.
  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [CNT_BITS-1:0] cnt,
                                                       input logic [PTR_BITS-1:0] idx);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    case (cnt)
      CNT_BITS'(2): begin
        case (idx)
          PTR_BITS'(0): w = WEIGHT_BITS'(5);
          PTR_BITS'(1): w = WEIGHT_BITS'(3);
          default:      w = '0;
        endcase
      end
      CNT_BITS'(3): begin
        case (idx)
          PTR_BITS'(0): w = WEIGHT_BITS'(8);
          PTR_BITS'(1): w = WEIGHT_BITS'(5);
          PTR_BITS'(2): w = WEIGHT_BITS'(3);
          default:      w = '0;
        endcase
      end
      CNT_BITS'(4): begin
        case (idx)
          PTR_BITS'(0): w = WEIGHT_BITS'(6);
          PTR_BITS'(1): w = WEIGHT_BITS'(4);
          PTR_BITS'(2): w = WEIGHT_BITS'(3);
          PTR_BITS'(3): w = WEIGHT_BITS'(3);
          default:      w = '0;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Final right shift of the weighted sum for a given fill count.
  function automatic logic [SHIFT_BITS-1:0] shift_of(input logic [CNT_BITS-1:0] cnt);
    logic [SHIFT_BITS-1:0] s;
    case (cnt)
      CNT_BITS'(2): s = SHIFT_BITS'(3);
      CNT_BITS'(3): s = SHIFT_BITS'(4);
      CNT_BITS'(4): s = SHIFT_BITS'(4);
      default:      s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/tdwa_mac.sv =====
// Shared multiply-accumulate unit for the x and y weighted sums.
module tdwa_mac (
  input  logic                          clk,
  input  tdwa_pkg::mac_ctl_t            ctl,
  input  logic [tdwa_pkg::COORD_BITS-1:0] x_val,
  input  logic [tdwa_pkg::COORD_BITS-1:0] y_val,
  output logic [tdwa_pkg::ACC_BITS-1:0]   acc_x,
  output logic [tdwa_pkg::ACC_BITS-1:0]   acc_y
);
  import tdwa_pkg::*;

  logic [ACC_BITS-1:0] prod_x;
  logic [ACC_BITS-1:0] prod_y;

  // One weighted term per coordinate each cycle.
  assign prod_x = ACC_BITS'(x_val) * ACC_BITS'(ctl.weight);
  assign prod_y = ACC_BITS'(y_val) * ACC_BITS'(ctl.weight);

  // Accumulators are cleared when ctl.clr is set, at the start of each sample.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (ctl.en) begin
      acc_x <= acc_x + prod_x;
      acc_y <= acc_y + prod_y;
    end
  end

endmodule

// ===== design/touch_dejitter_weighted_average.sv =====
// Top level of the touch de-jitter filter: history ring, sequencer and output register.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data (pen_up, sample_x, sample_y)
//   out     | output    | out_valid / out_stall| out_data (out_x, out_y)
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (jump_threshold)
//
// A pen-up item is handled in S_IDLE. A sample passes S_DIST, then S_MAC to sum n stored
// samples (n 0 or 2 to 4), then S_DONE: the single shared multiply-accumulate unit adds one
// history entry per cycle. The output register lets a new item enter while a result waits.
// Synchronous reset empties the history and sets the threshold to 100. A stalled output
// holds the sequencer in its final state only while the output register is still full.
module touch_dejitter_weighted_average (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tdwa_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tdwa_pkg::out_t                   out_data,
  input  logic                             cfg_wr_en,
  input  logic [tdwa_pkg::THRESH_BITS-1:0] cfg_wr_data
);
  import tdwa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIST = 4'b0010,
    S_MAC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [THRESH_BITS-1:0] jump_threshold;
  logic [PTR_BITS-1:0]    write_ptr;
  logic [CNT_BITS-1:0]    fill_count;
  logic [CNT_BITS-1:0]    fill_count_next;
  logic [PTR_BITS-1:0]    mac_idx;
  logic [COORD_BITS-1:0]  samp_x;
  logic [COORD_BITS-1:0]  samp_y;
  logic [COORD_BITS-1:0]  hist_x [HIST_DEPTH];
  logic [COORD_BITS-1:0]  hist_y [HIST_DEPTH];

  logic                   in_accept;
  logic [PTR_BITS-1:0]    rd_addr;
  logic [COORD_BITS-1:0]  rd_x;
  logic [COORD_BITS-1:0]  rd_y;
  logic [COORD_BITS-1:0]  dx;
  logic [COORD_BITS-1:0]  dy;
  logic [THRESH_BITS-1:0] distance;
  logic                   jump;
  logic [CNT_BITS-1:0]    kept_count;
  logic                   mac_last;
  logic                   out_load;
  logic [ACC_BITS-1:0]    acc_x;
  logic [ACC_BITS-1:0]    acc_y;
  logic [ACC_BITS-1:0]    sum_x;
  logic [ACC_BITS-1:0]    sum_y;
  mac_ctl_t               mac_ctl;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Single read port on the ring: newest entry minus the sequencer's index.
  assign rd_addr = write_ptr - PTR_BITS'(1) - mac_idx;
  assign rd_x    = hist_x[rd_addr];
  assign rd_y    = hist_y[rd_addr];

  // Manhattan distance from the newest stored sample.
  assign dx       = (samp_x > rd_x) ? (samp_x - rd_x) : (rd_x - samp_x);
  assign dy       = (samp_y > rd_y) ? (samp_y - rd_y) : (rd_y - samp_y);
  assign distance = THRESH_BITS'(dx) + THRESH_BITS'(dy);
  assign jump     = (fill_count != '0) && (distance > jump_threshold);

  // Fill count after this sample enters the ring: restarts at one after a jump, else saturates at the depth.
  always_comb begin
    kept_count = jump ? '0 : fill_count;
    if (kept_count == CNT_BITS'(HIST_DEPTH)) begin
      fill_count_next = kept_count;
    end else begin
      fill_count_next = kept_count + CNT_BITS'(1);
    end
  end

  assign mac_last = (mac_idx == PTR_BITS'(fill_count - CNT_BITS'(1)));
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Drive the shared multiply-accumulate unit.
  always_comb begin
    mac_ctl.clr    = (state == S_DIST);
    mac_ctl.en     = (state == S_MAC);
    mac_ctl.weight = weight_of(fill_count, mac_idx);
  end

  tdwa_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .x_val (rd_x),
    .y_val (rd_y),
    .acc_x (acc_x),
    .acc_y (acc_y)
  );

  assign sum_x = acc_x >> shift_of(fill_count);
  assign sum_y = acc_y >> shift_of(fill_count);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && !in_data.pen_up) begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        state_next = (fill_count_next == CNT_BITS'(1)) ? S_DONE : S_MAC;
      end
      S_MAC: begin
        if (mac_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      jump_threshold <= JUMP_RESET;
      write_ptr      <= '0;
      fill_count     <= '0;
      mac_idx        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        jump_threshold <= cfg_wr_data;
      end
      if (in_accept && in_data.pen_up) begin
        write_ptr  <= '0;
        fill_count <= '0;
      end
      if (state == S_DIST) begin
        write_ptr  <= write_ptr + PTR_BITS'(1);
        fill_count <= fill_count_next;
      end
      if (state == S_MAC && !mac_last) begin
        mac_idx <= mac_idx + PTR_BITS'(1);
      end else begin
        mac_idx <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: captured sample, history ring and result.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      samp_x <= in_data.sample_x;
      samp_y <= in_data.sample_y;
    end
    if (state == S_DIST) begin
      hist_x[write_ptr] <= samp_x;
      hist_y[write_ptr] <= samp_y;
    end
    if (out_load) begin
      if (fill_count == CNT_BITS'(1)) begin
        out_data.out_x <= samp_x;
        out_data.out_y <= samp_y;
      end else begin
        out_data.out_x <= sum_x[COORD_BITS-1:0];
        out_data.out_y <= sum_y[COORD_BITS-1:0];
      end
    end
  end

  // A pen-up item empties the history on the next edge.
  a_pen_up_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.pen_up |=> fill_count == '0 && write_ptr == '0)
    else $error("pen-up did not clear the history");

  // The summing loop only runs with at least two stored samples.
  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> fill_count >= CNT_BITS'(2) && fill_count <= CNT_BITS'(HIST_DEPTH))
    else $error("summing with an invalid fill count");

  // Each sample advances the write pointer by exactly one slot.
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    state == S_DIST |=> write_ptr == $past(write_ptr) + PTR_BITS'(1))
    else $error("write pointer did not advance");

  // An accepted sample starts the distance step right away.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept && !in_data.pen_up |=> state == S_DIST)
    else $error("accepted sample did not start processing");

  // A result is loaded only once the sequencer has finished an item.
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("result load did not complete the item");

endmodule
